[design/dpm_pkg.sv]
package dpm_pkg;

    // default geometry
    localparam int DPM_FRAMES = 4;
    localparam int DPM_VPAGES = 8;
    localparam int DPM_WPP    = 2;

    // fixed field widths
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int ADDR_SPAN  = 1 << ADDR_W;
    localparam int EVPG_W     = 3;
    localparam int FIDX_OUT_W = 2;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EVICT,
        ST_FILL,
        ST_ACCESS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take_req;
        logic lookup_hit;
        logic claim_free;
        logic scan_start;
        logic scan_step;
        logic evict_step;
        logic fill_step;
        logic access;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic scan_last;
        logic xfer_last;
        logic out_free;
    } status_t;

endpackage

[design/demand_paged_memory_lru.sv]
// Demand-paged word memory with LRU frame replacement.
// Input channel (in_valid/in_stall) takes one access word: req_type, address,
// write_value. Output channel (out_valid/out_stall) returns one result word
// per access: read_data, page_fault, evicted, evicted_page, frame_index,
// fault_count.
// One access at a time; the controller steps through the work and the next
// word is taken as soon as the controller is back in idle. States per access:
//   hit:                  lookup, access, done
//   miss, free frame:     lookup, fill, access, done
//   miss with eviction:   lookup, scan, evict, fill, access, done
// An eviction adds the victim scan (one stamp per cycle) and the word copies
// from frame memory to backing store before the fill.
// Reset empties all frames and clears the access clock and fault count; the
// backing store reads as all ones until a page is written back, tracked by
// one valid bit per page, so the block is ready straight after reset.
// A result waits in the output register while out_stall is high; a new access
// may be taken meanwhile but its result is held back until the old one goes.
module demand_paged_memory_lru #(
    parameter int FRAMES         = dpm_pkg::DPM_FRAMES,
    parameter int VIRTUAL_PAGES  = dpm_pkg::DPM_VPAGES,
    parameter int WORDS_PER_PAGE = dpm_pkg::DPM_WPP
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [dpm_pkg::ADDR_W-1:0]        address,
    input  logic signed [dpm_pkg::WORD_W-1:0] write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dpm_pkg::WORD_W-1:0] read_data,
    output logic                              page_fault,
    output logic                              evicted,
    output logic [dpm_pkg::EVPG_W-1:0]        evicted_page,
    output logic [dpm_pkg::FIDX_OUT_W-1:0]    frame_index,
    output logic [dpm_pkg::WORD_W-1:0]        fault_count
);
    import dpm_pkg::*;

    cmd_t    cmd;
    status_t sts;

    dpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dpm_datapath #(
        .FRAMES         (FRAMES),
        .VIRTUAL_PAGES  (VIRTUAL_PAGES),
        .WORDS_PER_PAGE (WORDS_PER_PAGE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .address      (address),
        .write_value  (write_value),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .read_data    (read_data),
        .page_fault   (page_fault),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .frame_index  (frame_index),
        .fault_count  (fault_count)
    );

endmodule

[design/dpm_ctrl.sv]
module dpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dpm_pkg::status_t sts,
    output logic             in_stall,
    output dpm_pkg::cmd_t    cmd
);
    import dpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (sts.hit)
                begin
                    cmd.lookup_hit = 1'b1;
                    state_next     = ST_ACCESS;
                end
                else if (!sts.full)
                begin
                    cmd.claim_free = 1'b1;
                    state_next     = ST_FILL;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.evict_step = 1'b1;
                if (sts.xfer_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.xfer_last)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/dpm_datapath.sv]
module dpm_datapath #(
    parameter int FRAMES         = dpm_pkg::DPM_FRAMES,
    parameter int VIRTUAL_PAGES  = dpm_pkg::DPM_VPAGES,
    parameter int WORDS_PER_PAGE = dpm_pkg::DPM_WPP
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpm_pkg::cmd_t                     cmd,
    output dpm_pkg::status_t                  sts,
    input  logic                              req_type,
    input  logic [dpm_pkg::ADDR_W-1:0]        address,
    input  logic signed [dpm_pkg::WORD_W-1:0] write_value,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic signed [dpm_pkg::WORD_W-1:0] read_data,
    output logic                              page_fault,
    output logic                              evicted,
    output logic [dpm_pkg::EVPG_W-1:0]        evicted_page,
    output logic [dpm_pkg::FIDX_OUT_W-1:0]    frame_index,
    output logic [dpm_pkg::WORD_W-1:0]        fault_count
);
    import dpm_pkg::*;

    localparam int FIDX_W   = $clog2(FRAMES);
    localparam int FU_W     = $clog2(FRAMES + 1);
    localparam int PG_W     = $clog2(VIRTUAL_PAGES);
    localparam int OFF_W    = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;
    localparam int CNT_W    = $clog2(WORDS_PER_PAGE + 1);
    localparam int FW_DEPTH = FRAMES * WORDS_PER_PAGE;
    localparam int BS_DEPTH = VIRTUAL_PAGES * WORDS_PER_PAGE;
    localparam int FW_AW    = $clog2(FW_DEPTH);
    localparam int BS_AW    = $clog2(BS_DEPTH);

    // latched request
    logic                 is_write_reg;
    logic [PG_W-1:0]      page_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [WORD_W-1:0]    wval_reg;

    // frame bookkeeping
    logic [PG_W-1:0]      frame_page_reg [FRAMES];
    logic [WORD_W-1:0]    stamp_reg [FRAMES];
    logic [FU_W-1:0]      frames_used_reg;
    logic [WORD_W-1:0]    clock_reg;
    logic [WORD_W-1:0]    fault_total_reg;
    logic [VIRTUAL_PAGES-1:0] page_valid_reg;

    // per-access working state
    logic [FIDX_W-1:0]    slot_reg;
    logic [FIDX_W-1:0]    best_reg;
    logic [WORD_W-1:0]    best_stamp_reg;
    logic [FIDX_W-1:0]    scan_idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 fault_reg;
    logic                 ev_reg;
    logic [PG_W-1:0]      ev_page_reg;

    // result register
    logic                 out_valid_reg;
    logic [WORD_W-1:0]    rdata_out_reg;
    logic                 fault_out_reg;
    logic                 ev_out_reg;
    logic [PG_W-1:0]      ev_page_out_reg;
    logic [FIDX_W-1:0]    slot_out_reg;
    logic [WORD_W-1:0]    fault_count_out_reg;

    // memories
    logic [WORD_W-1:0]    fw_mem [FW_DEPTH];
    logic [WORD_W-1:0]    bs_mem [BS_DEPTH];
    logic [WORD_W-1:0]    fw_rdata_reg;
    logic [WORD_W-1:0]    bs_rdata_reg;

    logic                 fw_we;
    logic [FW_AW-1:0]     fw_waddr;
    logic [WORD_W-1:0]    fw_wdata;
    logic                 fw_re;
    logic [FW_AW-1:0]     fw_raddr;
    logic                 bs_we;
    logic [BS_AW-1:0]     bs_waddr;
    logic                 bs_re;
    logic [BS_AW-1:0]     bs_raddr;

    logic [PG_W-1:0]      in_page;
    logic [OFF_W-1:0]     in_offset;
    logic                 hit;
    logic [FIDX_W-1:0]    hit_idx;
    logic                 older;
    logic [FIDX_W-1:0]    best_next;
    logic [WORD_W-1:0]    best_stamp_next;
    logic                 xfer_last;
    logic                 scan_last;
    logic                 out_free;
    logic [CNT_W-1:0]     cnt_prev;

    // address split, one entry per address value
    always_comb
    begin
        in_page   = '0;
        in_offset = '0;
        for (int a = 0; a < ADDR_SPAN; a++)
        begin
            if (address == ADDR_W'(a))
            begin
                in_page   = PG_W'((a / WORDS_PER_PAGE) % VIRTUAL_PAGES);
                in_offset = OFF_W'(a % WORDS_PER_PAGE);
            end
        end
    end

    // lowest filled frame holding the page
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if ((FU_W'(i) < frames_used_reg) && (frame_page_reg[i] == page_reg))
            begin
                hit     = 1'b1;
                hit_idx = FIDX_W'(i);
            end
        end
    end

    // strict compare keeps the lower index on a tie
    assign older           = stamp_reg[scan_idx_reg] < best_stamp_reg;
    assign best_next       = older ? scan_idx_reg : best_reg;
    assign best_stamp_next = older ? stamp_reg[scan_idx_reg] : best_stamp_reg;

    assign scan_last = scan_idx_reg == FIDX_W'(FRAMES - 1);
    assign xfer_last = cnt_reg == CNT_W'(WORDS_PER_PAGE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_prev  = cnt_reg - CNT_W'(1);

    assign sts.hit       = hit;
    assign sts.full      = frames_used_reg == FU_W'(FRAMES);
    assign sts.scan_last = scan_last;
    assign sts.xfer_last = xfer_last;
    assign sts.out_free  = out_free;

    // memory port steering
    always_comb
    begin
        fw_we    = 1'b0;
        fw_waddr = '0;
        fw_wdata = wval_reg;
        fw_re    = 1'b0;
        fw_raddr = '0;
        bs_we    = 1'b0;
        bs_waddr = '0;
        bs_re    = 1'b0;
        bs_raddr = '0;
        if (cmd.evict_step)
        begin
            fw_re    = !xfer_last;
            fw_raddr = FW_AW'(32'(slot_reg) * WORDS_PER_PAGE + 32'(cnt_reg));
            bs_we    = cnt_reg != '0;
            bs_waddr = BS_AW'(32'(ev_page_reg) * WORDS_PER_PAGE + 32'(cnt_prev));
        end
        if (cmd.fill_step)
        begin
            bs_re    = !xfer_last;
            bs_raddr = BS_AW'(32'(page_reg) * WORDS_PER_PAGE + 32'(cnt_reg));
            fw_we    = cnt_reg != '0;
            fw_waddr = FW_AW'(32'(slot_reg) * WORDS_PER_PAGE + 32'(cnt_prev));
            // a page never written back still holds its reset value
            fw_wdata = page_valid_reg[page_reg] ? bs_rdata_reg : '1;
        end
        if (cmd.access)
        begin
            fw_we    = is_write_reg == REQ_WRITE;
            fw_re    = is_write_reg == REQ_READ;
            fw_waddr = FW_AW'(32'(slot_reg) * WORDS_PER_PAGE + 32'(offset_reg));
            fw_raddr = fw_waddr;
            fw_wdata = wval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fw_we)
        begin
            fw_mem[fw_waddr] <= fw_wdata;
        end
        if (fw_re)
        begin
            fw_rdata_reg <= fw_mem[fw_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
        begin
            bs_mem[bs_waddr] <= fw_rdata_reg;
        end
        if (bs_re)
        begin
            bs_rdata_reg <= bs_mem[bs_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_used_reg <= '0;
            clock_reg       <= '0;
            fault_total_reg <= '0;
            page_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_req)
            begin
                clock_reg <= clock_reg + WORD_W'(1);
            end
            if (cmd.claim_free)
            begin
                frames_used_reg <= frames_used_reg + FU_W'(1);
            end
            if (cmd.claim_free || cmd.scan_start)
            begin
                fault_total_reg <= fault_total_reg + WORD_W'(1);
            end
            if (cmd.evict_step && xfer_last)
            begin
                page_valid_reg[ev_page_reg] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            is_write_reg <= req_type;
            page_reg     <= in_page;
            offset_reg   <= in_offset;
            wval_reg     <= write_value;
            fault_reg    <= 1'b0;
            ev_reg       <= 1'b0;
            ev_page_reg  <= '0;
        end
        if (cmd.lookup_hit)
        begin
            slot_reg <= hit_idx;
        end
        if (cmd.claim_free)
        begin
            slot_reg  <= FIDX_W'(frames_used_reg);
            fault_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        if (cmd.scan_start)
        begin
            fault_reg      <= 1'b1;
            best_reg       <= '0;
            best_stamp_reg <= stamp_reg[0];
            scan_idx_reg   <= FIDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            best_reg       <= best_next;
            best_stamp_reg <= best_stamp_next;
            scan_idx_reg   <= scan_idx_reg + FIDX_W'(1);
            if (scan_last)
            begin
                slot_reg    <= best_next;
                ev_reg      <= 1'b1;
                ev_page_reg <= frame_page_reg[best_next];
                cnt_reg     <= '0;
            end
        end
        if (cmd.evict_step || cmd.fill_step)
        begin
            cnt_reg <= xfer_last ? '0 : cnt_reg + CNT_W'(1);
        end
        if (cmd.fill_step && xfer_last)
        begin
            frame_page_reg[slot_reg] <= page_reg;
        end
        if (cmd.access)
        begin
            stamp_reg[slot_reg] <= clock_reg;
        end
        if (cmd.emit)
        begin
            rdata_out_reg       <= (is_write_reg == REQ_WRITE) ? '0 : fw_rdata_reg;
            fault_out_reg       <= fault_reg;
            ev_out_reg          <= ev_reg;
            ev_page_out_reg     <= ev_page_reg;
            slot_out_reg        <= slot_reg;
            fault_count_out_reg <= fault_total_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_out_reg;
    assign page_fault   = fault_out_reg;
    assign evicted      = ev_out_reg;
    assign evicted_page = EVPG_W'(ev_page_out_reg);
    assign frame_index  = FIDX_OUT_W'(slot_out_reg);
    assign fault_count  = fault_count_out_reg;

endmodule

[design/dpm_checker.sv]
module dpm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [dpm_pkg::WORD_W-1:0] read_data,
    input logic                              page_fault,
    input logic                              evicted,
    input logic [dpm_pkg::EVPG_W-1:0]        evicted_page,
    input logic [dpm_pkg::FIDX_OUT_W-1:0]    frame_index,
    input logic [dpm_pkg::WORD_W-1:0]        fault_count
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_data) && $stable(fault_count)
            && $stable(frame_index) && $stable(page_fault))
        else $error("result word changed while stalled");

    // eviction only ever happens as part of a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> page_fault)
        else $error("eviction reported without a fault");

    a_evpage_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_page == '0)
        else $error("evicted page set with no eviction");

    // a faulting access has counted at least one fault
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_fault |-> fault_count != '0)
        else $error("fault count zero on a fault");

endmodule

bind demand_paged_memory_lru dpm_checker u_dpm_checker (.*);
